FILE: hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache package
// Shared widths, types and limits for the LFU key cache and its victim
// selection logic.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_W  = 32;
  localparam int CNT_W  = 16;
  localparam int COST_W = 8;
  localparam int TOT_W  = 32;
  localparam int SLOT_W = 3;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [COST_W-1:0] cost_t;
  typedef logic [TOT_W-1:0]  total_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // Saturation limits
  localparam count_t CNT_MAX = '1;
  localparam total_t TOT_MAX = '1;

endpackage

FILE: hdl/lfu_victim_sel.sv
// ----------------------------------------------------------------------------
// LFU victim selection
// Picks the entry to replace on a miss: the lowest empty entry from index 1
// upward, otherwise the entry with the least use count (lowest index on
// ties), which covers an empty entry 0 as well.
// ----------------------------------------------------------------------------
module lfu_victim_sel
  import lfu_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  count_t                       cnt_i [ENTRIES],
  output logic [$clog2(ENTRIES)-1:0]   victim_o
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int LEAVES = 1 << IDX_W;
  localparam int NODES  = 2 * LEAVES - 1;

  // Min tree: one extra bit on the count so padding leaves always lose
  logic [CNT_W:0]   node_cnt [NODES];
  logic [IDX_W-1:0] node_idx [NODES];

  for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
    if (l < ENTRIES) begin : g_real
      assign node_cnt[LEAVES-1+l] = {1'b0, cnt_i[l]};
    end else begin : g_pad
      assign node_cnt[LEAVES-1+l] = {1'b1, {CNT_W{1'b0}}};
    end
    assign node_idx[LEAVES-1+l] = IDX_W'(l);
  end

  // Left child wins ties, so the lower index is kept
  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    logic take_right;
    assign take_right  = node_cnt[2*n+2] < node_cnt[2*n+1];
    assign node_cnt[n] = take_right ? node_cnt[2*n+2] : node_cnt[2*n+1];
    assign node_idx[n] = take_right ? node_idx[2*n+2] : node_idx[2*n+1];
  end

  // Lowest empty entry among index 1 and up
  logic             empty_found;
  logic [IDX_W-1:0] empty_idx;

  always_comb begin
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = ENTRIES - 1; i >= 1; i--) begin
      if (cnt_i[i] == '0) begin
        empty_found = 1'b1;
        empty_idx   = IDX_W'(i);
      end
    end
  end

  assign victim_o = empty_found ? empty_idx : node_idx[0];

endmodule

FILE: hdl/lfu_cache_hit_counter.sv
// ----------------------------------------------------------------------------
// LFU cache hit counter
// Fully associative key cache with least-frequently-used replacement and
// saturating cost totals.
// ----------------------------------------------------------------------------
// One request is taken every cycle when the result side keeps up; a
// request leaves the input register once the result register is free.
// A request is captured in an input register, then a single pass of logic
// (key match across all entries, the min-count tree for the victim and the
// saturating total adders) updates the entries and loads the result
// register. That pass is the critical path and grows with ENTRIES as a
// log2-deep compare tree. Entry state updates in the same cycle, so
// back-to-back requests for the same key see each other. The slot field
// carries the low 3 bits of the entry index. Entries are empty after reset;
// no warm-up is needed.
module lfu_cache_hit_counter
  import lfu_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [31:0] in_key,
  input  logic [7:0]        in_miss_cost,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [2:0]        out_slot,
  output logic [31:0]       out_cost_uncached,
  output logic [31:0]       out_cost_cached
);

  localparam int IDX_W = $clog2(ENTRIES);

  // Input register
  logic  s1_valid_r;
  key_t  s1_key_r;
  cost_t s1_cost_r;

  // Entry state and totals
  key_t   key_r     [ENTRIES];
  key_t   key_nxt   [ENTRIES];
  count_t cnt_r     [ENTRIES];
  count_t cnt_nxt   [ENTRIES];
  total_t tot_unc_r, tot_unc_nxt;
  total_t tot_cac_r, tot_cac_nxt;

  // Result register
  logic   out_valid_r;
  logic   out_hit_r;
  slot_t  out_slot_r;
  total_t out_unc_r;
  total_t out_cac_r;

  logic adv;

  // Handshake: the pass fires when the result register is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_key_r  <= key_t'(in_key);
      s1_cost_r <= in_miss_cost;
    end
  end

  // Key match against occupied entries, lowest index first
  logic             hit;
  logic [IDX_W-1:0] hit_idx;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0 && key_r[i] == s1_key_r) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Victim for a miss
  logic [IDX_W-1:0] victim;

  lfu_victim_sel #(
    .ENTRIES (ENTRIES)
  ) u_victim (
    .cnt_i    (cnt_r),
    .victim_o (victim)
  );

  // Saturating totals
  logic [TOT_W:0] unc_sum;
  logic [TOT_W:0] cac_sum;
  total_t         unc_sat;
  total_t         cac_sat;

  assign unc_sum = {1'b0, tot_unc_r} + {{(TOT_W+1-COST_W){1'b0}}, s1_cost_r};
  assign cac_sum = {1'b0, tot_cac_r} + {{(TOT_W+1-COST_W){1'b0}}, s1_cost_r};
  assign unc_sat = unc_sum[TOT_W] ? TOT_MAX : unc_sum[TOT_W-1:0];
  assign cac_sat = cac_sum[TOT_W] ? TOT_MAX : cac_sum[TOT_W-1:0];

  logic [IDX_W-1:0] sel_idx;
  assign sel_idx = hit ? hit_idx : victim;

  // Next entry state
  always_comb begin
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    tot_unc_nxt = tot_unc_r;
    tot_cac_nxt = tot_cac_r;
    if (adv) begin
      tot_unc_nxt = unc_sat;
      if (hit) begin
        if (cnt_r[hit_idx] != CNT_MAX) begin
          cnt_nxt[hit_idx] = cnt_r[hit_idx] + count_t'(1);
        end
      end else begin
        tot_cac_nxt     = cac_sat;
        key_nxt[victim] = s1_key_r;
        cnt_nxt[victim] = count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        cnt_r[i] <= '0;
      end
      tot_unc_r <= '0;
      tot_cac_r <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      tot_unc_r <= tot_unc_nxt;
      tot_cac_r <= tot_cac_nxt;
    end
  end

  // Keys are only read behind a nonzero count
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r  <= hit;
      out_slot_r <= SLOT_W'(sel_idx);
      out_unc_r  <= unc_sat;
      out_cac_r  <= hit ? tot_cac_r : cac_sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_cost_uncached = out_unc_r;
  assign out_cost_cached   = out_cac_r;

endmodule

FILE: test/tb_lfu_cache_hit_counter.sv
// ----------------------------------------------------------------------------
// LFU cache hit counter testbench
// Drives keyed requests into the cache and predicts hit, slot and both cost
// totals with a shadow copy of the entries and use counts. Covers empty-slot
// handling, fill order, least-count replacement with ties, a hot key that
// survives thrashing, output backpressure and mixed random traffic with idling.
// ----------------------------------------------------------------------------
module tb_lfu_cache_hit_counter;
  import lfu_pkg::*;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_GAP     = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 250;
  localparam int MAX_PRINTED = 40;
  localparam int HOT_HITS    = 40;

  typedef struct packed {
    logic   hit;
    slot_t  slot;
    total_t cost_uncached;
    total_t cost_cached;
  } lookup_outcome_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_key;
  logic [7:0]         in_miss_cost;
  logic               out_valid;
  logic               out_ready;
  logic               out_hit;
  logic [2:0]         out_slot;
  logic [31:0]        out_cost_uncached;
  logic [31:0]        out_cost_cached;

  // Shadow of the cache contents and running totals
  key_t   shadow_key [NUM_SLOTS];
  count_t shadow_count [NUM_SLOTS];
  total_t shadow_uncached;
  total_t shadow_cached;

  // Outcomes predicted for accepted requests, oldest first
  lookup_outcome_t lookups_due [$];

  bit source_paced;
  bit sink_paced;
  int sink_hold_left;
  int error_count;
  int results_checked;
  int requests_sent;
  int hit_total;
  int miss_total;

  lfu_cache_hit_counter #(
    .ENTRIES(NUM_SLOTS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key           (in_key),
    .in_miss_cost     (in_miss_cost),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_slot         (out_slot),
    .out_cost_uncached(out_cost_uncached),
    .out_cost_cached  (out_cost_cached)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic total_t add_saturating(total_t acc, cost_t cost);
    logic [TOT_W:0] sum;
    sum = {1'b0, acc} + {{(TOT_W+1-COST_W){1'b0}}, cost};
    return sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
  endfunction

  // Look the key up in the shadow cache, update it, and return the outcome
  function automatic lookup_outcome_t lookup_and_update(key_t key, cost_t cost);
    lookup_outcome_t res;
    int              victim;
    int              i;
    count_t          least;
    bit              found;
    bit              empty_seen;
    found      = 1'b0;
    empty_seen = 1'b0;
    res        = '0;
    shadow_uncached = add_saturating(shadow_uncached, cost);
    // empty entries never match
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (!found && shadow_count[i] != '0 && shadow_key[i] == key) begin
        found    = 1'b1;
        res.slot = slot_t'(i);
        if (shadow_count[i] != CNT_MAX) shadow_count[i]++;
      end
    end
    if (found) begin
      hit_total++;
    end else begin
      miss_total++;
      shadow_cached = add_saturating(shadow_cached, cost);
      // first empty from index 1 up, else least count with lowest index
      victim = 0;
      least  = shadow_count[0];
      for (i = 1; i < NUM_SLOTS; i++) begin
        if (!empty_seen) begin
          if (shadow_count[i] == '0) begin
            victim     = i;
            empty_seen = 1'b1;
          end else if (shadow_count[i] < least) begin
            least  = shadow_count[i];
            victim = i;
          end
        end
      end
      shadow_key[victim]   = key;
      shadow_count[victim] = count_t'(1);
      res.slot             = slot_t'(victim);
    end
    res.hit           = found;
    res.cost_uncached = shadow_uncached;
    res.cost_cached   = shadow_cached;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Offer one request, after a random gap when source pacing is on, and wait for its transaction
  task automatic send_request(input key_t key, input cost_t cost);
    int gap;
    gap = source_paced ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_key       <= key;
    in_miss_cost <= cost;
    do @(posedge clk); while (!in_ready);
    lookups_due.push_back(lookup_and_update(key, cost));
    requests_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Result side: random stall after each transaction when sink pacing is on, plus requested hold-offs
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_left > 0) begin
        out_ready <= 1'b0;
        sink_hold_left--;
      end else begin
        out_ready <= (stall_left == 0);
      end
      @(posedge clk);
      if (out_valid && out_ready) stall_left = sink_paced ? $urandom_range(0, MAX_GAP) : 0;
      else if (stall_left > 0) stall_left--;
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    lookup_outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lookups_due.size() == 0) begin
        report_mismatch("result transaction with no request outstanding");
      end else begin
        want = lookups_due.pop_front();
        results_checked++;
        if (out_hit !== want.hit)
          report_mismatch($sformatf("result %0d hit: got %0b, expected %0b",
                                    results_checked, out_hit, want.hit));
        if (out_slot !== want.slot)
          report_mismatch($sformatf("result %0d slot: got %0d, expected %0d",
                                    results_checked, out_slot, want.slot));
        if (out_cost_uncached !== want.cost_uncached)
          report_mismatch($sformatf("result %0d cost_uncached: got %0d, expected %0d",
                                    results_checked, out_cost_uncached,
                                    want.cost_uncached));
        if (out_cost_cached !== want.cost_cached)
          report_mismatch($sformatf("result %0d cost_cached: got %0d, expected %0d",
                                    results_checked, out_cost_cached,
                                    want.cost_cached));
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, lookups_due.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Key 0 on an empty cache, fill from slot 1 upward, slot 0 last
  task automatic test_fill_order();
    send_request(32'h0000_0000, 8'd0);
    send_request(32'h0000_0000, 8'd255);
    send_request(32'h7FFF_FFFF, 8'd1);
    send_request(32'h8000_0000, 8'd128);
    send_request(32'hFFFF_FFFF, 8'd2);
    send_request(32'h0000_0001, 8'd127);
    send_request(32'h5555_5555, 8'd254);
    send_request(32'hAAAA_AAAA, 8'd3);
    send_request(32'h1234_5678, 8'd64);
    send_request(32'h0000_0000, 8'd255);
    stop_sending();
  endtask

  // Full cache: least count wins, lowest index on ties, slot 0 included
  task automatic test_lfu_replacement();
    send_request(32'h8000_0000, 8'd10);
    send_request(32'h8000_0000, 8'd11);
    send_request(32'hDEAD_0001, 8'd12);
    send_request(32'hDEAD_0002, 8'd13);
    send_request(32'h7FFF_FFFF, 8'd14);
    send_request(32'hFFFF_FFFF, 8'd15);
    send_request(32'hDEAD_0003, 8'd16);
    send_request(32'hDEAD_0003, 8'd17);
    send_request(32'hDEAD_0003, 8'd18);
    send_request(32'hDEAD_0004, 8'd255);
    send_request(32'h1234_5678, 8'd0);
    send_request(32'h1234_5678, 8'd19);
    stop_sending();
  endtask

  // Build a high use count on one key back to back, then thrash the other
  // slots; the hot key must keep its slot throughout.
  task automatic test_hot_key();
    key_t hot_key;
    int   n;
    hot_key      = 32'h5A5A_0001;
    source_paced = 1'b0;
    sink_paced   = 1'b0;
    for (n = 0; n < HOT_HITS; n++) send_request(hot_key, cost_t'($urandom_range(0, 255)));
    for (n = 0; n < 12; n++) begin
      send_request(32'hBEEF_0000 + n, cost_t'($urandom_range(0, 255)));
      send_request(hot_key, cost_t'($urandom_range(0, 255)));
    end
    stop_sending();
  endtask

  // Result side held off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    int n;
    source_paced   = 1'b0;
    sink_paced     = 1'b0;
    sink_hold_left = HOLD_CYCLES;
    for (n = 0; n < 40; n++)
      send_request(32'h0000_0100 + $urandom_range(0, 11), cost_t'($urandom_range(0, 255)));
    stop_sending();
  endtask

  // Hot and cold keys from a per-block pool, with some fully random keys.
  // Each block of 100 takes the next of four idling mixes on the two sides, in turn.
  task automatic test_random_traffic(input int num_items);
    key_t  pool [16];
    key_t  key;
    cost_t cost;
    int    n;
    int    i;
    int    pick;
    for (n = 0; n < num_items; n++) begin
      if (n % 100 == 0) begin
        source_paced = ((n / 100) % 4) < 2;
        sink_paced   = ((n / 100) % 2) == 0;
        for (i = 0; i < 16; i++) pool[i] = $urandom;
        pool[$urandom_range(0, 15)] = 32'h0000_0000;
        pool[$urandom_range(0, 15)] = 32'h8000_0000;
        pool[$urandom_range(0, 15)] = 32'hFFFF_FFFF;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)      key = pool[$urandom_range(0, 4)];
      else if (pick < 90) key = pool[$urandom_range(5, 15)];
      else                key = $urandom;
      pick = $urandom_range(0, 9);
      if (pick == 0)      cost = '0;
      else if (pick == 1) cost = '1;
      else                cost = cost_t'($urandom_range(0, 255));
      send_request(key, cost);
    end
    stop_sending();
  endtask

  initial begin : main
    int i;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_key          = '0;
    in_miss_cost    = '0;
    source_paced    = 1'b1;
    sink_paced      = 1'b1;
    sink_hold_left  = 0;
    error_count     = 0;
    results_checked = 0;
    requests_sent   = 0;
    hit_total       = 0;
    miss_total      = 0;
    shadow_uncached = '0;
    shadow_cached   = '0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      shadow_key[i]   = '0;
      shadow_count[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_order();
    test_lfu_replacement();
    test_backpressure();
    test_hot_key();
    test_random_traffic(680);

    // Drain outstanding results, then watch for strays
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    // Totals near 2^32 need millions of max-cost requests, beyond one run
    $display("Covered %0d requests (%0d hits, %0d misses), %0d results compared.",
             requests_sent, hit_total, miss_total, results_checked);
    $display("Included fill order, LFU ties, a hot key under thrashing and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lfu_pkg.sv
hdl/lfu_victim_sel.sv
hdl/lfu_cache_hit_counter.sv
test/tb_lfu_cache_hit_counter.sv
